FILE: hdl/rmst_pkg.sv
`default_nettype none

package rmst_pkg;

  // fixed field widths
  localparam int unsigned VAL_W = 32;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned LEN_W = IDX_W + 1;
  localparam int unsigned LG_W  = 4;

  // command codes
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_QRD2,
    S_QCMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/rmst_ram.sv
`default_nettype none

module rmst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/range_minimum_sparse_table_unit.sv
`default_nettype none

// channel  direction  handshake           payload
// in_      input      in_valid/in_stall   in_cmd, in_value, in_from_index, in_to_index
// out_     output     out_valid/out_stall out_minimum, out_status
//
// A load writes the word to level 0, then does one read-modify-write of the table memory
// for each table level above level 0 that it fills, up to level LEVELS - 1. A query
// makes two reads through the single read port; clear and flagged commands go straight
// to the result. One word is in work at a time; the output register holds a finished
// word while the next is accepted. Reset (rst_n, synchronous) zeroes the element count,
// the state and out_valid; the table memory needs no clearing. out_stall holds a result
// in the output register and, once the next result is ready, holds the unit.

module range_minimum_sparse_table_unit #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LEVELS       = 11
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_cmd,
  input  wire logic signed [31:0] in_value,
  input  wire logic [9:0]         in_from_index,
  input  wire logic [9:0]         in_to_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_minimum,
  output logic [1:0]              out_status
);

  localparam int unsigned IW    = $clog2(MAX_ELEMENTS);
  localparam int unsigned LW    = $clog2(LEVELS);
  localparam int unsigned CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned AW    = LW + IW;
  localparam int unsigned DEPTH = LEVELS * (2 ** IW);
  localparam int unsigned CMP_W = (CW > rmst_pkg::IDX_W) ? CW : rmst_pkg::IDX_W;
  localparam int unsigned VW    = rmst_pkg::VAL_W;
  localparam int unsigned XW    = rmst_pkg::IDX_W;
  localparam int unsigned NW    = rmst_pkg::LEN_W;
  localparam int unsigned GW    = rmst_pkg::LG_W;

  rmst_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [LW-1:0]     lvl_r, lvl_nxt;
  logic [CW:0]       s_r, s_nxt;
  logic [CW:0]       step_r, step_nxt;
  logic signed [VW-1:0] prev_r, prev_nxt;
  logic [LW-1:0]     lg_r, lg_nxt;
  logic [IW-1:0]     second_r, second_nxt;
  logic signed [VW-1:0] res_min_r, res_min_nxt;
  rmst_pkg::status_t res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] out_min_r, out_min_nxt;
  rmst_pkg::status_t out_st_r, out_st_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [VW-1:0]     ram_rdata;

  rmst_pkg::cmd_t    cmd;
  logic              full;
  logic [NW-1:0]     q_len;
  logic [GW-1:0]     q_lg;
  logic [NW-1:0]     q_pow;
  logic [XW-1:0]     q_second;
  logic              q_bad;
  logic [CW:0]       s_dec;
  logic signed [VW-1:0] rd_val;
  logic signed [VW-1:0] run_min;

  // level table: entry {level, start} holds the minimum of 2^level elements
  rmst_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command decode and query range checks
  assign cmd  = rmst_pkg::cmd_t'(in_cmd);
  assign full = (count_r == CW'(MAX_ELEMENTS));

  always_comb begin
    q_len = {1'b0, in_to_index} - {1'b0, in_from_index} + NW'(1);
    q_lg  = '0;
    for (int i = 0; i < NW; i++) begin
      if (q_len[i]) begin
        q_lg = GW'(i);
      end
    end
  end

  assign q_pow    = NW'(1) << q_lg;
  assign q_second = XW'({1'b0, in_to_index} + NW'(1) - q_pow);
  assign q_bad    = (in_from_index > in_to_index) ||
                    (CMP_W'(in_to_index) >= CMP_W'(count_r)) ||
                    (int'(q_lg) >= LEVELS);

  // running minimum along the levels of a load, and the next window start
  assign rd_val  = $signed(ram_rdata);
  assign run_min = (rd_val < prev_r) ? rd_val : prev_r;
  assign s_dec   = s_r - step_r;

  // sequencer: next state, memory access and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lvl_nxt       = lvl_r;
    s_nxt         = s_r;
    step_nxt      = step_r;
    prev_nxt      = prev_r;
    lg_nxt        = lg_r;
    second_nxt    = second_r;
    res_min_nxt   = res_min_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_min_nxt   = out_min_r;
    out_st_nxt    = out_st_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      rmst_pkg::S_IDLE: begin
        if (in_valid) begin
          res_min_nxt = '0;
          res_st_nxt  = rmst_pkg::ST_OK;
          state_nxt   = rmst_pkg::S_DONE;
          case (cmd)
            rmst_pkg::CMD_LOAD: begin
              if (full) begin
                res_st_nxt = rmst_pkg::ST_FULL;
              end else begin
                // level 0 gets the word itself
                ram_we    = 1'b1;
                ram_waddr = {{LW{1'b0}}, IW'(count_r)};
                ram_wdata = in_value;
                prev_nxt  = in_value;
                count_nxt = count_r + CW'(1);
                if (count_r != '0) begin
                  ram_raddr = {{LW{1'b0}}, IW'(count_r - CW'(1))};
                  lvl_nxt   = LW'(1);
                  s_nxt     = (CW + 1)'(count_r) - (CW + 1)'(1);
                  step_nxt  = (CW + 1)'(2);
                  state_nxt = rmst_pkg::S_LOAD;
                end
              end
            end
            rmst_pkg::CMD_QUERY: begin
              if (q_bad) begin
                res_st_nxt = rmst_pkg::ST_BAD_RANGE;
              end else begin
                ram_raddr  = {LW'(q_lg), IW'(in_from_index)};
                lg_nxt     = LW'(q_lg);
                second_nxt = IW'(q_second);
                state_nxt  = rmst_pkg::S_QRD2;
              end
            end
            rmst_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      rmst_pkg::S_LOAD: begin
        // left half comes from memory, right half is the window just written
        ram_we    = 1'b1;
        ram_waddr = {lvl_r, s_r[IW-1:0]};
        ram_wdata = run_min;
        prev_nxt  = run_min;
        if ((lvl_r == LW'(LEVELS - 1)) || s_dec[CW]) begin
          state_nxt = rmst_pkg::S_DONE;
        end else begin
          ram_raddr = {lvl_r, s_dec[IW-1:0]};
          lvl_nxt   = lvl_r + LW'(1);
          s_nxt     = s_dec;
          step_nxt  = step_r << 1;
        end
      end

      rmst_pkg::S_QRD2: begin
        prev_nxt  = rd_val;
        ram_raddr = {lg_r, second_r};
        state_nxt = rmst_pkg::S_QCMP;
      end

      rmst_pkg::S_QCMP: begin
        res_min_nxt = run_min;
        state_nxt   = rmst_pkg::S_DONE;
      end

      rmst_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = res_min_r;
          out_st_nxt    = res_st_r;
          state_nxt     = rmst_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rmst_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmst_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    lvl_r     <= lvl_nxt;
    s_r       <= s_nxt;
    step_r    <= step_nxt;
    prev_r    <= prev_nxt;
    lg_r      <= lg_nxt;
    second_r  <= second_nxt;
    res_min_r <= res_min_nxt;
    res_st_r  <= res_st_nxt;
    out_min_r <= out_min_nxt;
    out_st_r  <= out_st_nxt;
  end

  // ports
  assign in_stall    = (state_r != rmst_pkg::S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_minimum = out_min_r;
  assign out_status  = out_st_r;

`ifndef SYNTH
  // element count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  // a flagged or non-query word carries a zero minimum when flagged
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != rmst_pkg::ST_OK)) |-> (out_minimum == '0))
    else $error("flagged word with nonzero minimum");

  // load walk never writes a window that starts before element zero
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmst_pkg::S_LOAD) |-> !s_r[CW])
    else $error("load window start negative");

  // accepted clear empties the array
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (cmd == rmst_pkg::CMD_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the array");
`endif

endmodule

`default_nettype wire
